@@ rtl/bda_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII converter.
// Used by bda_ctrl, bda_dpath and binary_to_decimal_ascii; no dependencies.
`default_nettype none

package bda_pkg;

   // Width of the converted integer (8 to 32).
   localparam int VALUE_BITS = 32;

   localparam int unsigned DIGIT_BASE = 10;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Division by ten as a multiply by 2^35/10 rounded up, exact for 32-bit operands.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          RECIP_BITS  = 32;

   // Number of decimal digits in the largest unsigned value of the given width.
   function automatic int num_digits(input int bits);
      longint unsigned v;
      int n;
      begin
         v = (64'd1 << bits) - 64'd1;
         n = 1;
         v = v / DIGIT_BASE;
         while (v != 0) begin
            n++;
            v = v / DIGIT_BASE;
         end
         return n;
      end
   endfunction

   localparam int MAX_DIGITS = num_digits(VALUE_BITS);
   localparam int IDX_BITS   = $clog2(MAX_DIGITS);
   localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);
   localparam int QUO_BITS   = VALUE_BITS - 3;
   localparam int PROD_BITS  = VALUE_BITS + RECIP_BITS;

   typedef struct packed {
      logic [31:0] value;
      logic        is_signed;
   } bda_req_type;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last;
   } bda_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic rem;
      logic emit_sign;
      logic emit_digit;
   } bda_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic neg;
      logic quo_zero;
      logic digits_full;
      logic idx_zero;
   } bda_stat_type;

endpackage

`default_nettype wire

@@ rtl/bda_dpath.sv @@
// Datapath of the converter: magnitude, divide-by-ten unit, digit buffer and
// the registered result stage. Depends on bda_pkg.
`default_nettype none

module bda_dpath
   import bda_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire bda_req_type  req_data,
   input  wire bda_cmd_type  cmd,
   output bda_stat_type      stat,
   output logic              rsp_valid,
   output bda_rsp_type       rsp_data
);

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff;
   logic [QUO_BITS-1:0]   quo_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [3:0]            dig_ff [MAX_DIGITS];
   bda_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_valid_ff;

   logic [VALUE_BITS-1:0] raw;
   logic                  neg_in;
   logic [PROD_BITS-1:0]  prod;
   logic [VALUE_BITS:0]   quo_x10;
   logic [VALUE_BITS-1:0] diff;
   logic [3:0]            rem_digit;

   // Sign and magnitude of a new item.
   always_comb begin
      raw    = req_data.value[VALUE_BITS-1:0];
      neg_in = req_data.is_signed & raw[VALUE_BITS-1];
      mag_in = neg_in ? (~raw + VALUE_BITS'(1)) : raw;
   end

   // Quotient by reciprocal multiply; remainder from the registered quotient.
   always_comb begin
      prod      = {{RECIP_BITS{1'b0}}, mag_ff} * {{VALUE_BITS{1'b0}}, RECIP_TEN};
      quo_x10   = {1'b0, quo_ff, 3'b000} + {3'b000, quo_ff, 1'b0};
      diff      = mag_ff - quo_x10[VALUE_BITS-1:0];
      rem_digit = diff[3:0];
   end

   // Result character for the current emit command.
   always_comb begin
      rsp_in.ascii_char = CHAR_ZERO + {4'b0000, dig_ff[idx_ff]};
      rsp_in.last       = (idx_ff == '0);
      if (cmd.emit_sign) begin
         rsp_in.ascii_char = CHAR_MINUS;
         rsp_in.last       = 1'b0;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         cnt_ff <= '0;
      end
      if (cmd.mul) begin
         quo_ff <= prod[RECIP_SHIFT +: QUO_BITS];
      end
      if (cmd.rem) begin
         dig_ff[cnt_ff[IDX_BITS-1:0]] <= rem_digit;
         mag_ff <= {3'b000, quo_ff};
         idx_ff <= cnt_ff[IDX_BITS-1:0];
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
      if (cmd.emit_digit) begin
         idx_ff <= idx_ff - IDX_BITS'(1);
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_sign | cmd.emit_digit;
      end
   end

   always_comb begin
      stat.neg         = neg_ff;
      stat.quo_zero    = (quo_ff == '0);
      stat.digits_full = (cnt_ff == CNT_BITS'(MAX_DIGITS - 1));
      stat.idx_zero    = (idx_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/bda_ctrl.sv @@
// Controller of the converter: sequences digit extraction and character output.
// Depends on bda_pkg.
`default_nettype none

module bda_ctrl
   import bda_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire bda_stat_type  stat,
   output bda_cmd_type        cmd,
   output logic               busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_REM,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   // Commands follow the current state.
   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && start;
      cmd.mul        = (state_ff == ST_MUL);
      cmd.rem        = (state_ff == ST_REM);
      cmd.emit_sign  = (state_ff == ST_SIGN);
      cmd.emit_digit = (state_ff == ST_DIGIT);
   end

   // State and busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_MUL;
                  busy_ff  <= 1'b1;
               end
            end
            ST_MUL: begin
               state_ff <= ST_REM;
            end
            ST_REM: begin
               if (stat.quo_zero || stat.digits_full) begin
                  state_ff <= stat.neg ? ST_SIGN : ST_DIGIT;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_SIGN: begin
               state_ff <= ST_DIGIT;
            end
            ST_DIGIT: begin
               if (stat.idx_zero) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

@@ rtl/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter.
// Instantiates bda_ctrl and bda_dpath; depends on bda_pkg.
//
//   Channel   Handshake             Payload
//   request   start / busy          req_data  (value, is_signed)
//   response  rsp_valid (strobe)    rsp_data  (ascii_char, last)
//
// A request is taken when start is high and busy is low. Each digit takes a
// multiply step and then a remainder step in the divide-by-ten unit, after which
// the minus sign, if any, and the digits leave one per cycle. The next request
// can be taken in the cycle that holds the final character.
// Synchronous reset returns the controller to idle and drops the strobe.
// The receiver cannot stall; every character is valid on the result ports for one cycle.
`default_nettype none

module binary_to_decimal_ascii
   import bda_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire bda_req_type  req_data,
   output logic              rsp_valid,
   output bda_rsp_type       rsp_data
);

   bda_cmd_type  cmd;
   bda_stat_type stat;

   bda_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   bda_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request transfer");

   // Nothing follows the final character of a number by itself.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result transfer right after final character");

   // Characters before the final one are sent while the block is busy.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("non-final character while idle");

   // Only a minus sign or a decimal digit is ever sent.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ascii_char == CHAR_MINUS) ||
                    (rsp_data.ascii_char >= CHAR_ZERO &&
                     rsp_data.ascii_char <= CHAR_ZERO + 8'd9))
      else $error("character outside minus and digits");
`endif

endmodule

`default_nettype wire

@@ tb/binary_to_decimal_ascii_checker.sv @@
// Checker for the binary to decimal ASCII converter: watches both channels,
// predicts the decimal text of each accepted number and compares it per character.
// Depends on bda_pkg for the payload types and character constants.

module binary_to_decimal_ascii_checker
   import bda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  bda_req_type req_data,
   input  logic        rsp_valid,
   input  bda_rsp_type rsp_data,
   output int          outstanding,
   output int          failures
);

   // A 32-bit magnitude never needs more than ten digits.
   localparam int DIGIT_LIMIT = 10;

   bda_rsp_type expected_chars[$];
   int          error_count;

   initial begin
      outstanding = 0;
      failures = 0;
      error_count = 0;
   end

   // Queue the characters of one number, sign first, most significant digit next.
   function automatic void queue_decimal_text(input bda_req_type number);
      longint unsigned mask;
      longint unsigned magnitude;
      logic [3:0]      digit_stack[DIGIT_LIMIT];
      int              count;
      bda_rsp_type     text_char;
      mask = (64'd1 << VALUE_BITS) - 64'd1;
      magnitude = number.value & mask;
      count = 0;
      if (number.is_signed && magnitude[VALUE_BITS-1]) begin
         text_char.ascii_char = CHAR_MINUS;
         text_char.last = 1'b0;
         expected_chars.push_back(text_char);
         magnitude = (~magnitude + 64'd1) & mask;
      end
      // Peel digits off the low end; zero still yields one digit.
      do begin
         digit_stack[count] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         count++;
      end while (magnitude != 0 && count < DIGIT_LIMIT);
      for (int i = count - 1; i >= 0; i--) begin
         text_char.ascii_char = CHAR_ZERO + 8'(digit_stack[i]);
         text_char.last = (i == 0);
         expected_chars.push_back(text_char);
      end
   endfunction

   // Predict on every request transfer and check every response transfer.
   always @(posedge clock) begin
      bda_rsp_type oldest;
      if (!reset) begin
         if (start && !busy) begin
            queue_decimal_text(req_data);
         end
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character %h with last %b", rsp_data.ascii_char,
                      rsp_data.last);
               error_count++;
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_data.ascii_char !== oldest.ascii_char) begin
                  $error("ascii_char mismatch: expected %h, actual %h",
                         oldest.ascii_char, rsp_data.ascii_char);
                  error_count++;
               end
               if (rsp_data.last !== oldest.last) begin
                  $error("last mismatch: expected %b, actual %b", oldest.last,
                         rsp_data.last);
                  error_count++;
               end
            end
         end
      end
      outstanding <= expected_chars.size();
      failures <= error_count;
   end

endmodule

@@ tb/binary_to_decimal_ascii_test.sv @@
// Top of the testbench for binary_to_decimal_ascii: clock, reset, number stimulus,
// watchdog and verdict. Depends on bda_pkg, binary_to_decimal_ascii and binary_to_decimal_ascii_checker.

module binary_to_decimal_ascii_test;
   import bda_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_NUMBERS = 100;
   localparam int SETTLE_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   bda_req_type req_data;
   logic        rsp_valid;
   bda_rsp_type rsp_data;
   int          outstanding;
   int          failures;
   int          stalled_cycles;

   binary_to_decimal_ascii i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   binary_to_decimal_ascii_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   // Clock with a 20-unit period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: give up when no transfer happens for too long.
   initial stalled_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one number until the block takes it, idling on about a quarter of
   // the cycles when idling is allowed.
   // Start stays high after the transfer so back-to-back numbers need no toggle.
   task automatic send_number(input logic [31:0] value, input logic is_signed,
                              input bit may_idle);
      bit accepted;
      req_data <= '{value: value, is_signed: is_signed};
      accepted = 1'b0;
      while (!accepted) begin
         start <= !(may_idle && $urandom_range(0, 99) < 25);
         @(posedge clock);
         accepted = start && !busy;
      end
   endtask

   // Stop offering numbers until every predicted character has come out.
   task automatic drain_text;
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] value;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed numbers: zero both ways, digit-count boundaries, sign extremes.
      send_number(32'd0, 1'b0, 1'b1);
      send_number(32'd0, 1'b1, 1'b1);
      send_number(32'd1, 1'b0, 1'b1);
      send_number(32'd1, 1'b1, 1'b1);
      send_number(32'd9, 1'b0, 1'b1);
      send_number(32'd10, 1'b0, 1'b1);
      send_number(32'd99, 1'b1, 1'b1);
      send_number(32'd100, 1'b0, 1'b1);
      send_number(32'd12345, 1'b1, 1'b1);
      send_number(32'h7FFF_FFFF, 1'b1, 1'b1);
      send_number(32'h7FFF_FFFF, 1'b0, 1'b1);
      send_number(32'h8000_0000, 1'b1, 1'b1);
      send_number(32'h8000_0000, 1'b0, 1'b1);
      send_number(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_number(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_number(32'd1000000000, 1'b0, 1'b1);
      send_number(32'd999999999, 1'b1, 1'b1);
      send_number(32'hFFFF_FFF6, 1'b1, 1'b1);
      send_number(32'hC465_3600, 1'b1, 1'b1);
      send_number(32'd4000000000, 1'b0, 1'b1);
      send_number(32'hAAAA_AAAA, 1'b1, 1'b1);
      send_number(32'h5555_5555, 1'b0, 1'b1);
      drain_text();

      // Random numbers spread over every digit count, signed and unsigned.
      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = $urandom >> $urandom_range(0, 31);
            2: value = $urandom_range(0, 99);
            default: value = ~($urandom >> $urandom_range(1, 31));
         endcase
         // Numbers 30 to 59 go back to back with no idle cycles.
         send_number(value, 1'($urandom_range(0, 1)), !(n >= 30 && n < 60));
         if (n == 70) begin
            drain_text();
         end
      end

      drain_text();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
